FILE: rtl/lph_pkg.sv
// Shared types, codes and constants for the landmark polygon heuristic block.
// No dependencies; imported by lph_alu, the top module and the testbench.
package lph_pkg;

  // Default sizes of the stores
  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int MAX_LANDMARKS_DEF = 16;

  // Field widths fixed by the interface
  localparam int VTX_W  = 10;
  localparam int LMK_W  = 4;
  localparam int DIST_W = 10;
  localparam int CNT_W  = 5;
  localparam int ACC_W  = 12;  // signed width of the shared subtractor

  // Reset value of the landmark count register
  localparam logic [CNT_W-1:0] LMK_COUNT_RESET = 5'd16;

  // Request codes
  localparam logic [1:0] REQ_WR_VTX = 2'd0;
  localparam logic [1:0] REQ_WR_MAT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Configuration register indexes
  localparam logic REG_LMK_COUNT = 1'b0;

  // One vertex store entry: owner and distance to that owner
  typedef struct packed {
    logic              owned;
    logic [LMK_W-1:0]  owner;
    logic              finite;
    logic [DIST_W-1:0] hops;
  } vtx_entry_t;

  // One landmark matrix entry
  typedef struct packed {
    logic              finite;
    logic [DIST_W-1:0] hops;
  } mat_entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QS,
    ST_QT,
    ST_QV,
    ST_QM,
    ST_ABS1,
    ST_ABS2,
    ST_P1A,
    ST_P1B,
    ST_P2A,
    ST_P2B,
    ST_DONE
  } state_t;

  // Control of the shared subtract / max unit
  typedef struct packed {
    logic clr;       // clear the running maximum
    logic use_tmp;   // minuend is the held partial difference
    logic abs_sel;   // take the magnitude of the difference
    logic load_tmp;  // hold the difference for the next step
    logic upd;       // fold the difference into the running maximum
  } alu_ctl_t;

endpackage

FILE: rtl/lph_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the vertex store and the landmark matrix.
module lph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port share one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lph_alu.sv
// Shared subtract, magnitude and running-maximum unit of the heuristic block.
// Depends on lph_pkg for the control struct and widths.
module lph_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lph_pkg::alu_ctl_t          ctl,
  input  logic [lph_pkg::DIST_W-1:0] op_a,
  input  logic [lph_pkg::DIST_W-1:0] op_b,
  output logic [lph_pkg::DIST_W-1:0] h_max
);
  import lph_pkg::*;

  logic signed [ACC_W-1:0] tmp_r;
  logic signed [ACC_W-1:0] minuend;
  logic signed [ACC_W-1:0] diff;
  logic signed [ACC_W-1:0] res;
  logic [DIST_W-1:0]       h_r;

  // One subtractor; the minuend is a fresh operand or the held partial
  always_comb begin
    minuend = ctl.use_tmp ? tmp_r : $signed({2'b00, op_a});
    diff    = minuend - $signed({2'b00, op_b});
    res     = (ctl.abs_sel && diff[ACC_W-1]) ? -diff : diff;
  end

  // Partial difference for the two-step polygon terms
  always_ff @(posedge clk) begin
    if (ctl.load_tmp) begin
      tmp_r <= diff;
    end
  end

  // Running maximum, floor of zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else if (ctl.clr) begin
      h_r <= '0;
    end else if (ctl.upd && (res > $signed({2'b00, h_r}))) begin
      h_r <= res[DIST_W-1:0];
    end
  end

  assign h_max = h_r;

endmodule

FILE: rtl/landmark_polygon_heuristic.sv
// Landmark polygon heuristic: vertex/landmark stores, sequencer and APB register.
// Depends on lph_pkg, lph_ram and lph_alu.
//
// After reset the block runs a clearing pass over max(MAX_VERTICES,
// MAX_LANDMARKS*MAX_LANDMARKS) addresses (1024 by default) with in_ready low;
// the APB register is writable throughout. A vertex or matrix write
// transaction completes in the cycle it is accepted and the block is ready
// again in the next one. From the acceptance of a query until its result
// is offered, the single-port vertex memory reads source, target and
// current vertex one after another (the landmark matrix read overlaps the
// last), then one shared subtractor steps through six operations to build
// the four landmark terms and their maximum. The block holds one query at
// a time and keeps accepting transactions while a finished result waits
// on out_ready.
module landmark_polygon_heuristic #(
  parameter int MAX_VERTICES  = lph_pkg::MAX_VERTICES_DEF,
  parameter int MAX_LANDMARKS = lph_pkg::MAX_LANDMARKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [lph_pkg::VTX_W-1:0]  in_entry_vertex,
  input  logic [lph_pkg::LMK_W-1:0]  in_entry_owner,
  input  logic                       in_entry_owned,
  input  logic [lph_pkg::DIST_W-1:0] in_entry_distance,
  input  logic                       in_entry_finite,
  input  logic [lph_pkg::LMK_W-1:0]  in_row_landmark,
  input  logic [lph_pkg::LMK_W-1:0]  in_col_landmark,
  input  logic [lph_pkg::VTX_W-1:0]  in_query_source,
  input  logic [lph_pkg::VTX_W-1:0]  in_query_target,
  input  logic [lph_pkg::VTX_W-1:0]  in_query_vertex,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lph_pkg::DIST_W-1:0] out_heuristic_value,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lph_pkg::*;

  localparam int VAW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int MAT_DEPTH = MAX_LANDMARKS * MAX_LANDMARKS;
  localparam int MAW       = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int CLR_DEPTH = (MAX_VERTICES > MAT_DEPTH) ? MAX_VERTICES : MAT_DEPTH;
  localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int VEW       = $bits(vtx_entry_t);
  localparam int MEW       = $bits(mat_entry_t);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     clr_ctr_r, clr_ctr_nxt;
  logic [CNT_W-1:0]  lmk_count_r;

  logic [VAW-1:0]    q_s_r, q_t_r, q_v_r;
  logic              s_in_r, t_in_r, v_in_r;
  vtx_entry_t        es_r, et_r, ev_r;

  logic              accept;
  logic [31:0]       ev32, qs32, qt32, qv32, clr32, wr_mat32, rd_mat32;

  logic              vtx_we, vtx_re;
  logic [VAW-1:0]    vtx_addr;
  vtx_entry_t        vtx_wdata;
  logic [VEW-1:0]    vtx_rdata_raw;
  vtx_entry_t        vtx_rdata;

  logic              mat_we, mat_re;
  logic [MAW-1:0]    mat_addr;
  mat_entry_t        mat_wdata;
  logic [MEW-1:0]    mat_rdata_raw;
  mat_entry_t        mat_rdata;

  alu_ctl_t          alu_ctl;
  logic [DIST_W-1:0] alu_a, alu_b, h_max;

  logic              ks_ok, kt_ok;
  logic              f_ls_t, f_ls_v, f_ls_s, f_lt_s, f_lt_v, f_lt_t, f_m;

  logic              out_load;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_hv_r;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lmk_count_r <= LMK_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LMK_COUNT)) begin
      lmk_count_r <= pwdata[CNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_LMK_COUNT) ? 32'(lmk_count_r) : 32'd0;

  // Index arithmetic at 32 bits, then cut to address width
  assign ev32     = 32'(in_entry_vertex);
  assign qs32     = 32'(in_query_source);
  assign qt32     = 32'(in_query_target);
  assign qv32     = 32'(in_query_vertex);
  assign clr32    = 32'(clr_ctr_r);
  assign wr_mat32 = 32'(in_row_landmark) * 32'(MAX_LANDMARKS) + 32'(in_col_landmark);
  assign rd_mat32 = 32'(es_r.owner) * 32'(MAX_LANDMARKS) + 32'(vtx_rdata.owner);

  // Vertex store port
  always_comb begin
    vtx_we    = 1'b0;
    vtx_re    = 1'b0;
    vtx_addr  = q_v_r;
    vtx_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        vtx_we   = (clr32 < 32'(MAX_VERTICES));
        vtx_addr = clr32[VAW-1:0];
      end
      ST_IDLE: begin
        vtx_we           = accept && (in_req_type == REQ_WR_VTX) &&
                           (ev32 < 32'(MAX_VERTICES));
        vtx_addr         = ev32[VAW-1:0];
        vtx_wdata.owned  = in_entry_owned;
        vtx_wdata.owner  = in_entry_owned ? in_entry_owner : '0;
        vtx_wdata.finite = in_entry_finite;
        vtx_wdata.hops   = in_entry_finite ? in_entry_distance : '0;
      end
      ST_QS: begin
        vtx_re   = 1'b1;
        vtx_addr = q_s_r;
      end
      ST_QT: begin
        vtx_re   = 1'b1;
        vtx_addr = q_t_r;
      end
      ST_QV: begin
        vtx_re   = 1'b1;
        vtx_addr = q_v_r;
      end
      default: begin
        vtx_re = 1'b0;
      end
    endcase
  end

  // Landmark matrix port
  always_comb begin
    mat_we    = 1'b0;
    mat_re    = 1'b0;
    mat_addr  = rd_mat32[MAW-1:0];
    mat_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mat_we   = (clr32 < 32'(MAT_DEPTH));
        mat_addr = clr32[MAW-1:0];
      end
      ST_IDLE: begin
        mat_we           = accept && (in_req_type == REQ_WR_MAT) &&
                           (32'(in_row_landmark) < 32'(MAX_LANDMARKS)) &&
                           (32'(in_col_landmark) < 32'(MAX_LANDMARKS));
        mat_addr         = wr_mat32[MAW-1:0];
        mat_wdata.finite = in_entry_finite;
        mat_wdata.hops   = in_entry_finite ? in_entry_distance : '0;
      end
      ST_QV: begin
        mat_re = 1'b1;
      end
      default: begin
        mat_re = 1'b0;
      end
    endcase
  end

  lph_ram #(.WIDTH(VEW), .DEPTH(MAX_VERTICES), .AW(VAW)) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .re    (vtx_re),
    .addr  (vtx_addr),
    .wdata (vtx_wdata),
    .rdata (vtx_rdata_raw)
  );
  assign vtx_rdata = vtx_entry_t'(vtx_rdata_raw);

  lph_ram #(.WIDTH(MEW), .DEPTH(MAT_DEPTH), .AW(MAW)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .re    (mat_re),
    .addr  (mat_addr),
    .wdata (mat_wdata),
    .rdata (mat_rdata_raw)
  );
  assign mat_rdata = mat_entry_t'(mat_rdata_raw);

  // Query operands and fetched entries
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_QUERY)) begin
      q_s_r  <= qs32[VAW-1:0];
      q_t_r  <= qt32[VAW-1:0];
      q_v_r  <= qv32[VAW-1:0];
      s_in_r <= (qs32 < 32'(MAX_VERTICES));
      t_in_r <= (qt32 < 32'(MAX_VERTICES));
      v_in_r <= (qv32 < 32'(MAX_VERTICES));
    end
    if (state_r == ST_QT) es_r <= vtx_rdata;
    if (state_r == ST_QV) et_r <= vtx_rdata;
    if (state_r == ST_QM) ev_r <= vtx_rdata;
  end

  // Owner checks and term availability
  always_comb begin
    ks_ok  = s_in_r && es_r.owned && (32'(es_r.owner) < 32'(lmk_count_r)) &&
             (32'(es_r.owner) < 32'(MAX_LANDMARKS));
    kt_ok  = t_in_r && et_r.owned && (32'(et_r.owner) < 32'(lmk_count_r)) &&
             (32'(et_r.owner) < 32'(MAX_LANDMARKS));
    f_ls_s = ks_ok && es_r.finite;
    f_ls_t = ks_ok && t_in_r && et_r.owned && (et_r.owner == es_r.owner) && et_r.finite;
    f_ls_v = ks_ok && v_in_r && ev_r.owned && (ev_r.owner == es_r.owner) && ev_r.finite;
    f_lt_t = kt_ok && et_r.finite;
    f_lt_s = kt_ok && s_in_r && es_r.owned && (es_r.owner == et_r.owner) && es_r.finite;
    f_lt_v = kt_ok && v_in_r && ev_r.owned && (ev_r.owner == et_r.owner) && ev_r.finite;
    f_m    = ks_ok && kt_ok && mat_rdata.finite;
  end

  // Sequencer state and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ctr_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_ctr_r <= clr_ctr_nxt;
    end
  end

  // Next state and shared unit control
  always_comb begin
    state_nxt   = state_r;
    clr_ctr_nxt = clr_ctr_r;
    alu_ctl     = '0;
    alu_a       = es_r.hops;
    alu_b       = ev_r.hops;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_ctr_nxt = clr_ctr_r + 1'b1;
        if (clr_ctr_r == CW'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        alu_ctl.clr = accept;
        if (accept && (in_req_type == REQ_QUERY)) begin
          state_nxt = ST_QS;
        end
      end
      ST_QS: state_nxt = ST_QT;
      ST_QT: state_nxt = ST_QV;
      ST_QV: state_nxt = ST_QM;
      ST_QM: state_nxt = ST_ABS1;
      // |d(ks,t) - d(ks,v)|
      ST_ABS1: begin
        alu_a           = et_r.hops;
        alu_b           = ev_r.hops;
        alu_ctl.abs_sel = 1'b1;
        alu_ctl.upd     = f_ls_t && f_ls_v;
        state_nxt       = ST_ABS2;
      end
      // |d(kt,s) - d(kt,v)|
      ST_ABS2: begin
        alu_a           = es_r.hops;
        alu_b           = ev_r.hops;
        alu_ctl.abs_sel = 1'b1;
        alu_ctl.upd     = f_lt_s && f_lt_v;
        state_nxt       = ST_P1A;
      end
      // M - d(ks,v) - d(kt,t)
      ST_P1A: begin
        alu_a            = mat_rdata.hops;
        alu_b            = ev_r.hops;
        alu_ctl.load_tmp = 1'b1;
        state_nxt        = ST_P1B;
      end
      ST_P1B: begin
        alu_b           = et_r.hops;
        alu_ctl.use_tmp = 1'b1;
        alu_ctl.upd     = f_m && f_ls_v && f_lt_t;
        state_nxt       = ST_P2A;
      end
      // M - d(ks,s) - d(kt,v)
      ST_P2A: begin
        alu_a            = mat_rdata.hops;
        alu_b            = es_r.hops;
        alu_ctl.load_tmp = 1'b1;
        state_nxt        = ST_P2B;
      end
      ST_P2B: begin
        alu_b           = ev_r.hops;
        alu_ctl.use_tmp = 1'b1;
        alu_ctl.upd     = f_m && f_ls_s && f_lt_v;
        state_nxt       = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  lph_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .op_a  (alu_a),
    .op_b  (alu_b),
    .h_max (h_max)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hv_r <= h_max;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_heuristic_value = out_hv_r;

  // Checks
  a_query_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_QUERY)) |=> (state_r == ST_QS))
    else $error("query transaction did not start the fetch sequence");

  a_no_write_during_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_QS) || (state_r == ST_QT) || (state_r == ST_QV)) |->
      (!vtx_we && !mat_we))
    else $error("store written while a query is reading it");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result offered outside the done step");

  a_clear_ctr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> $stable(clr_ctr_r))
    else $error("clear counter moved after the clearing pass");

endmodule

FILE: tb/sv/tb_landmark_polygon_heuristic.sv
// Testbench for landmark_polygon_heuristic: directed and random table writes and
// queries, checked against an in-bench heuristic predictor. Depends on lph_pkg and
// the RTL of the block only.
module tb_landmark_polygon_heuristic;
  timeunit 1ns;
  timeprecision 1ps;

  import lph_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int N_VTX        = MAX_VERTICES_DEF;
  localparam int N_LMK        = MAX_LANDMARKS_DEF;
  localparam int GRAPH_ROUNDS = 12;
  localparam int POOL_SIZE    = 12;
  localparam int STALL_HOLD   = 300;

  // One input transaction
  typedef struct {
    logic [1:0]        req;
    logic [VTX_W-1:0]  entry_vertex;
    logic [LMK_W-1:0]  entry_owner;
    logic              entry_owned;
    logic [DIST_W-1:0] entry_distance;
    logic              entry_finite;
    logic [LMK_W-1:0]  row;
    logic [LMK_W-1:0]  col;
    logic [VTX_W-1:0]  src;
    logic [VTX_W-1:0]  dst;
    logic [VTX_W-1:0]  cur;
  } lph_req_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [VTX_W-1:0]  in_entry_vertex;
  logic [LMK_W-1:0]  in_entry_owner;
  logic              in_entry_owned;
  logic [DIST_W-1:0] in_entry_distance;
  logic              in_entry_finite;
  logic [LMK_W-1:0]  in_row_landmark;
  logic [LMK_W-1:0]  in_col_landmark;
  logic [VTX_W-1:0]  in_query_source;
  logic [VTX_W-1:0]  in_query_target;
  logic [VTX_W-1:0]  in_query_vertex;
  logic              out_valid;
  logic              out_ready;
  logic [DIST_W-1:0] out_heuristic_value;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor copy of the block state
  bit                vtx_owned  [N_VTX];
  logic [LMK_W-1:0]  vtx_owner  [N_VTX];
  bit                vtx_finite [N_VTX];
  logic [DIST_W-1:0] vtx_dist   [N_VTX];
  bit                mat_finite [N_LMK][N_LMK];
  logic [DIST_W-1:0] mat_dist   [N_LMK][N_LMK];
  logic [CNT_W-1:0]  lmk_count;

  logic [DIST_W-1:0] expected_heuristics[$];
  logic [DIST_W-1:0] want_heuristic;
  logic [VTX_W-1:0]  graph_pool[POOL_SIZE];

  bit tx_idle;
  bit rx_idle;
  int hold_cycles;
  int n_errors;
  int n_checked;
  int n_writes;
  int n_settings;

  landmark_polygon_heuristic i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_entry_vertex     (in_entry_vertex),
    .in_entry_owner      (in_entry_owner),
    .in_entry_owned      (in_entry_owned),
    .in_entry_distance   (in_entry_distance),
    .in_entry_finite     (in_entry_finite),
    .in_row_landmark     (in_row_landmark),
    .in_col_landmark     (in_col_landmark),
    .in_query_source     (in_query_source),
    .in_query_target     (in_query_target),
    .in_query_vertex     (in_query_vertex),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_heuristic_value (out_heuristic_value),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Owning landmark of x, -1 when unowned or beyond the active landmark count
  function automatic int owner_of_vertex(input logic [VTX_W-1:0] x);
    int active;
    active = (lmk_count < N_LMK) ? int'(lmk_count) : N_LMK;
    if (!vtx_owned[x] || int'(vtx_owner[x]) >= active) return -1;
    return int'(vtx_owner[x]);
  endfunction

  // Distance of x from landmark k; 0 when not available
  function automatic bit dist_from_landmark(input int k, input logic [VTX_W-1:0] x,
                                            output int d);
    d = 0;
    if (k < 0 || owner_of_vertex(x) != k || !vtx_finite[x]) return 1'b0;
    d = int'(vtx_dist[x]);
    return 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] estimate_heuristic(input logic [VTX_W-1:0] s,
                                                           input logic [VTX_W-1:0] t,
                                                           input logic [VTX_W-1:0] v);
    int ks, kt, m, best, term;
    int ls_t, ls_v, ls_s, lt_s, lt_v, lt_t;
    bit f_ls_t, f_ls_v, f_ls_s, f_lt_s, f_lt_v, f_lt_t, f_m;
    ks     = owner_of_vertex(s);
    kt     = owner_of_vertex(t);
    f_ls_t = dist_from_landmark(ks, t, ls_t);
    f_ls_v = dist_from_landmark(ks, v, ls_v);
    f_ls_s = dist_from_landmark(ks, s, ls_s);
    f_lt_s = dist_from_landmark(kt, s, lt_s);
    f_lt_v = dist_from_landmark(kt, v, lt_v);
    f_lt_t = dist_from_landmark(kt, t, lt_t);
    f_m    = 1'b0;
    m      = 0;
    if (ks >= 0 && kt >= 0 && mat_finite[ks][kt]) begin
      f_m = 1'b1;
      m   = int'(mat_dist[ks][kt]);
    end
    best = 0;
    // two triangle terms
    if (f_ls_t && f_ls_v) begin
      term = (ls_t > ls_v) ? ls_t - ls_v : ls_v - ls_t;
      if (term > best) best = term;
    end
    if (f_lt_s && f_lt_v) begin
      term = (lt_s > lt_v) ? lt_s - lt_v : lt_v - lt_s;
      if (term > best) best = term;
    end
    // two polygon terms, negative ones lose to zero
    if (f_m && f_ls_v && f_lt_t) begin
      term = m - ls_v - lt_t;
      if (term > best) best = term;
    end
    if (f_m && f_ls_s && f_lt_v) begin
      term = m - ls_s - lt_v;
      if (term > best) best = term;
    end
    return best[DIST_W-1:0];
  endfunction

  // Update the tables or queue the expected heuristic for one accepted transaction
  function automatic void apply_request(input lph_req_t r);
    case (r.req)
      REQ_WR_VTX: begin
        vtx_owned[r.entry_vertex]  = r.entry_owned;
        vtx_owner[r.entry_vertex]  = r.entry_owned ? r.entry_owner : '0;
        vtx_finite[r.entry_vertex] = r.entry_finite;
        vtx_dist[r.entry_vertex]   = r.entry_finite ? r.entry_distance : '0;
        n_writes++;
      end
      REQ_WR_MAT: begin
        mat_finite[r.row][r.col] = r.entry_finite;
        mat_dist[r.row][r.col]   = r.entry_finite ? r.entry_distance : '0;
        n_writes++;
      end
      REQ_QUERY: begin
        expected_heuristics.push_back(estimate_heuristic(r.src, r.dst, r.cur));
      end
      default: begin
      end
    endcase
  endfunction

  // ------------------------------------------------------------ item builders

  function automatic lph_req_t random_request();
    lph_req_t r;
    r.req            = 2'($urandom_range(0, 3));
    r.entry_vertex   = VTX_W'($urandom);
    r.entry_owner    = LMK_W'($urandom);
    r.entry_owned    = 1'($urandom);
    r.entry_distance = DIST_W'($urandom);
    r.entry_finite   = 1'($urandom);
    r.row            = LMK_W'($urandom);
    r.col            = LMK_W'($urandom);
    r.src            = VTX_W'($urandom);
    r.dst            = VTX_W'($urandom);
    r.cur            = VTX_W'($urandom);
    return r;
  endfunction

  function automatic lph_req_t vertex_write(input logic [VTX_W-1:0] v,
                                            input logic [LMK_W-1:0] own, input logic owned,
                                            input logic [DIST_W-1:0] d, input logic fin);
    lph_req_t r;
    r                = random_request();
    r.req            = REQ_WR_VTX;
    r.entry_vertex   = v;
    r.entry_owner    = own;
    r.entry_owned    = owned;
    r.entry_distance = d;
    r.entry_finite   = fin;
    return r;
  endfunction

  function automatic lph_req_t matrix_write(input logic [LMK_W-1:0] row,
                                            input logic [LMK_W-1:0] col,
                                            input logic [DIST_W-1:0] d, input logic fin);
    lph_req_t r;
    r                = random_request();
    r.req            = REQ_WR_MAT;
    r.row            = row;
    r.col            = col;
    r.entry_distance = d;
    r.entry_finite   = fin;
    return r;
  endfunction

  function automatic lph_req_t query_request(input logic [VTX_W-1:0] s,
                                             input logic [VTX_W-1:0] t,
                                             input logic [VTX_W-1:0] v);
    lph_req_t r;
    r     = random_request();
    r.req = REQ_QUERY;
    r.src = s;
    r.dst = t;
    r.cur = v;
    return r;
  endfunction

  function automatic lph_req_t unused_request();
    lph_req_t r;
    r     = random_request();
    r.req = REQ_UNUSED;
    return r;
  endfunction

  // Short hop counts make the polygon terms positive; extremes now and then
  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DIST_W'($urandom);
      default: return DIST_W'($urandom_range(1, 63));
    endcase
  endfunction

  // Mostly a vertex of the current graph, sometimes any vertex
  function automatic logic [VTX_W-1:0] graph_vertex();
    if ($urandom_range(0, 9) == 0) return VTX_W'($urandom);
    return graph_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  // ------------------------------------------------------------ channel tasks

  task automatic send_request(input lph_req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= r.req;
    in_entry_vertex   <= r.entry_vertex;
    in_entry_owner    <= r.entry_owner;
    in_entry_owned    <= r.entry_owned;
    in_entry_distance <= r.entry_distance;
    in_entry_finite   <= r.entry_finite;
    in_row_landmark   <= r.row;
    in_col_landmark   <= r.col;
    in_query_source   <= r.src;
    in_query_target   <= r.dst;
    in_query_vertex   <= r.cur;
    do @(posedge clk); while (!in_ready);
    apply_request(r);
  endtask

  // Drain all results; a write may still be in flight after the last one
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_heuristics.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One APB transfer; psel stays high so transfers can run back to back
  task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_LMK_COUNT, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_landmark_count(input logic [CNT_W-1:0] value);
    logic [31:0] rd;
    apb_transfer(1'b1, 32'(value), rd);
    apb_transfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lmk_count = value;
    n_settings++;
    if (rd[CNT_W-1:0] !== value) begin
      $error("landmark_count: expected %0d, actual %0d", value, rd[CNT_W-1:0]);
      n_errors++;
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid && hold_cycles == 0) @(posedge clk);
      end
    end
  end

  // Result check against the oldest expected heuristic
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_heuristics.size() == 0) begin
        $error("heuristic_value: no result expected, actual %0d", out_heuristic_value);
        n_errors++;
      end else begin
        want_heuristic = expected_heuristics.pop_front();
        n_checked++;
        if (out_heuristic_value !== want_heuristic) begin
          $error("heuristic_value: expected %0d, actual %0d",
                 want_heuristic, out_heuristic_value);
          n_errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests

  task automatic test_directed();
    // empty tables: everything unowned
    send_request(query_request(10'd0, 10'd1023, 10'd512));
    // entries on landmarks 0 and 15 with distance extremes
    send_request(vertex_write(10'd0, 4'd0, 1'b1, 10'd0, 1'b1));
    send_request(vertex_write(10'd1, 4'd0, 1'b1, 10'd40, 1'b1));
    send_request(vertex_write(10'd2, 4'd15, 1'b1, 10'd0, 1'b1));
    send_request(vertex_write(10'd1023, 4'd15, 1'b1, 10'd1023, 1'b1));
    send_request(vertex_write(10'd3, 4'd15, 1'b1, 10'd5, 1'b1));
    // unowned write drops the owner, infinite write drops the distance
    send_request(vertex_write(10'd4, 4'd15, 1'b0, 10'd7, 1'b1));
    send_request(vertex_write(10'd5, 4'd0, 1'b1, 10'd1023, 1'b0));
    send_request(matrix_write(4'd0, 4'd15, 10'd1023, 1'b1));
    send_request(matrix_write(4'd15, 4'd0, 10'd1023, 1'b0));
    send_request(matrix_write(4'd15, 4'd15, 10'd0, 1'b1));
    // unused request code: ignored
    send_request(unused_request());
    // polygon terms, triangle terms, unowned and infinite operands
    send_request(query_request(10'd0, 10'd2, 10'd1));
    send_request(query_request(10'd0, 10'd2, 10'd3));
    send_request(query_request(10'd0, 10'd1, 10'd0));
    send_request(query_request(10'd1023, 10'd2, 10'd3));
    send_request(query_request(10'd0, 10'd1, 10'd1));
    send_request(query_request(10'd0, 10'd2, 10'd4));
    send_request(query_request(10'd0, 10'd1, 10'd5));
    send_request(query_request(10'd2, 10'd0, 10'd1));
    // zero landmarks: every vertex unowned
    settle_block();
    set_landmark_count(5'd0);
    send_request(query_request(10'd0, 10'd2, 10'd1));
    send_request(query_request(10'd0, 10'd1, 10'd0));
    // one landmark: owner 15 now counts as unowned
    settle_block();
    set_landmark_count(5'd1);
    send_request(query_request(10'd0, 10'd2, 10'd1));
    send_request(query_request(10'd0, 10'd1, 10'd0));
    settle_block();
    set_landmark_count(5'd16);
  endtask

  // Small random graphs: fill a vertex pool and matrix, then query around it
  task automatic test_random_graphs();
    int lmk_hi;
    for (int round = 0; round < GRAPH_ROUNDS; round++) begin
      settle_block();
      case (round % 4)
        1:       set_landmark_count(5'd1);
        3:       set_landmark_count(CNT_W'($urandom_range(2, 15)));
        default: set_landmark_count(5'd16);
      endcase
      tx_idle = (round % 3) != 1;
      rx_idle = (round % 3) != 2 && round != 4;
      lmk_hi  = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(1, 4);
      for (int i = 0; i < POOL_SIZE; i++) graph_pool[i] = VTX_W'($urandom_range(0, N_VTX-1));
      for (int i = 0; i < POOL_SIZE; i++) begin
        send_request(vertex_write(graph_pool[i], LMK_W'($urandom_range(0, lmk_hi)),
                                  $urandom_range(0, 9) != 0, random_distance(),
                                  $urandom_range(0, 6) != 0));
      end
      for (int i = 0; i < 6; i++) begin
        send_request(matrix_write(LMK_W'($urandom_range(0, lmk_hi)),
                                  LMK_W'($urandom_range(0, lmk_hi)),
                                  ($urandom_range(0, 7) == 0) ? '1 :
                                    DIST_W'($urandom_range(200, 1023)),
                                  $urandom_range(0, 6) != 0));
      end
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(0, 15))
          0:       send_request(unused_request());
          1:       send_request(random_request());
          2:       send_request(vertex_write(graph_vertex(), LMK_W'($urandom_range(0, lmk_hi)),
                                             1'b1, random_distance(), 1'b1));
          default: send_request(query_request(graph_vertex(), graph_vertex(),
                                              graph_vertex()));
        endcase
      end
    end
  endtask

  // Receiver holds off while queries keep coming, so the input side stalls
  task automatic test_receiver_stall();
    tx_idle     = 1'b0;
    hold_cycles = STALL_HOLD;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) begin
        send_request(vertex_write(graph_vertex(), LMK_W'($urandom_range(0, 3)),
                                  1'b1, random_distance(), 1'b1));
      end else begin
        send_request(query_request(graph_vertex(), graph_vertex(), graph_vertex()));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ------------------------------------------------------------- main flow

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_WR_VTX;
    in_entry_vertex   <= '0;
    in_entry_owner    <= '0;
    in_entry_owned    <= 1'b0;
    in_entry_distance <= '0;
    in_entry_finite   <= 1'b0;
    in_row_landmark   <= '0;
    in_col_landmark   <= '0;
    in_query_source   <= '0;
    in_query_target   <= '0;
    in_query_vertex   <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    lmk_count         = LMK_COUNT_RESET;
    tx_idle           = 1'b1;
    rx_idle           = 1'b1;
    hold_cycles       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_graphs();
    test_receiver_stall();

    // drain and let the block go quiet
    in_valid <= 1'b0;
    while (expected_heuristics.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (expected_heuristics.size() != 0) begin
      $error("heuristic_value: %0d results never arrived", expected_heuristics.size());
      n_errors++;
    end
    $display("Checked %0d query results after %0d table writes and %0d landmark count",
             n_checked, n_writes, n_settings);
    $display("settings, including a long receiver stall with queries backing up.");
    if (n_errors == 0) begin
      $display("tb_landmark_polygon_heuristic passed");
    end else begin
      $display("tb_landmark_polygon_heuristic failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("tb_landmark_polygon_heuristic failed");
    $finish;
  end

endmodule
